// File: design/assert_macros.svh
// assertion macros used by interval_timer_channel
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ITC_ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ITC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: design/itc_pkg.sv
// types, codes and helpers for the interval timer channel
// no dependencies
package itc_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;

  typedef enum logic [1:0] {
    CMD_CTRL_WR = 2'd0,
    CMD_DATA_WR = 2'd1,
    CMD_DATA_RD = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACC_LATCH = 2'd0,
    ACC_LO    = 2'd1,
    ACC_HI    = 2'd2,
    ACC_LOHI  = 2'd3
  } access_t;

  typedef enum logic [1:0] {
    MODE_CNT  = 2'd0,
    MODE_RATE = 2'd2,
    MODE_SQR  = 2'd3
  } mode_t;

  localparam logic [1:0] ChanSel0 = 2'b00;

  // modes 1, 4, 5 count like mode 0; 6 and 7 alias 2 and 3
  function automatic mode_t eff_mode(input logic [2:0] m);
    mode_t r;
    case (m)
      3'd2, 3'd6: r = MODE_RATE;
      3'd3, 3'd7: r = MODE_SQR;
      default:    r = MODE_CNT;
    endcase
    return r;
  endfunction

endpackage

// File: design/itc_if.sv
// valid/ready channel interfaces for the interval timer channel
// depends on itc_pkg
interface itc_in_if;
  logic                       valid;
  logic                       ready;
  logic [itc_pkg::CmdW-1:0]   command;
  logic [itc_pkg::ByteW-1:0]  write_data;

  modport source (output valid, output command, output write_data, input ready);
  modport sink   (input valid, input command, input write_data, output ready);
endinterface

interface itc_out_if;
  logic                       valid;
  logic                       ready;
  logic [itc_pkg::ByteW-1:0]  read_data;
  logic                       out_level;
  logic                       irq_pulse;

  modport source (output valid, output read_data, output out_level, output irq_pulse,
                  input ready);
  modport sink   (input valid, input read_data, input out_level, input irq_pulse,
                  output ready);
endinterface

// File: design/interval_timer_channel.sv
// interval timer channel: one 8254-style counter with command, data and tick items
// depends on itc_pkg, itc_if.sv and assert_macros.svh
//
//   channel  | dir | payload                           | handshake
//   in_if    | in  | command, write_data                | valid / ready
//   out_if   | out | read_data, out_level, irq_pulse   | valid / ready
//
// one item per cycle sustained while out_if does not stall the result
// input register feeds decode and counter update, result register drives out_if
// rst_n is synchronous; clears both stage valids and all counter state
// a stalled result holds; the input register still takes one more item if it is empty
`include "assert_macros.svh"

module interval_timer_channel (
  input  logic      clk,
  input  logic      rst_n,
  itc_in_if.sink    in_if,
  itc_out_if.source out_if
);

  // input register
  logic                          s1_valid_r;
  itc_pkg::cmd_t                 s1_cmd_r;
  logic [itc_pkg::ByteW-1:0]     s1_data_r;

  // result register
  logic                          out_valid_r;
  logic [itc_pkg::ByteW-1:0]     out_rd_r;
  logic                          out_level_r;
  logic                          out_irq_r;

  // channel state
  logic [itc_pkg::CountW-1:0]    reload_r, reload_nxt;
  logic [itc_pkg::CountW-1:0]    counter_r, counter_nxt;
  logic [itc_pkg::CountW-1:0]    latched_r, latched_nxt;
  logic                          latch_valid_r, latch_valid_nxt;
  logic                          wr_high_r, wr_high_nxt;
  logic                          rd_high_r, rd_high_nxt;
  itc_pkg::mode_t                mode_r, mode_nxt;
  itc_pkg::access_t              access_r, access_nxt;
  logic                          pin_r, pin_nxt;
  logic                          armed_r, armed_nxt;

  logic                          adv;
  logic                          proc;
  logic                          arm;
  itc_pkg::access_t              cmd_acc;
  logic [itc_pkg::CountW-1:0]    src;
  logic [itc_pkg::CountW-1:0]    dec1;
  logic [itc_pkg::CountW-1:0]    dec2;
  logic [itc_pkg::ByteW-1:0]     rd_nxt;

  assign adv         = !out_valid_r || out_if.ready;
  assign proc        = s1_valid_r && adv;
  assign in_if.ready = !s1_valid_r || adv;

  assign cmd_acc = itc_pkg::access_t'(s1_data_r[5:4]);
  assign src     = latch_valid_r ? latched_r : counter_r;
  assign dec1    = counter_r - 16'd1;
  assign dec2    = counter_r - 16'd2;

  always_comb begin
    reload_nxt      = reload_r;
    counter_nxt     = counter_r;
    latched_nxt     = latched_r;
    latch_valid_nxt = latch_valid_r;
    wr_high_nxt     = wr_high_r;
    rd_high_nxt     = rd_high_r;
    mode_nxt        = mode_r;
    access_nxt      = access_r;
    pin_nxt         = pin_r;
    armed_nxt       = armed_r;
    arm             = 1'b0;
    rd_nxt          = '0;

    if (proc) begin
      unique case (s1_cmd_r)
        itc_pkg::CMD_CTRL_WR: begin
          if (s1_data_r[7:6] == itc_pkg::ChanSel0) begin
            if (cmd_acc == itc_pkg::ACC_LATCH) begin
              if (!latch_valid_r) begin
                latched_nxt     = counter_r;
                latch_valid_nxt = 1'b1;
              end
            end else begin
              mode_nxt        = itc_pkg::eff_mode(s1_data_r[3:1]);
              access_nxt      = cmd_acc;
              wr_high_nxt     = 1'b0;
              rd_high_nxt     = 1'b0;
              latch_valid_nxt = 1'b0;
              armed_nxt       = 1'b0;
              pin_nxt         = (mode_nxt != itc_pkg::MODE_CNT);
            end
          end
        end
        itc_pkg::CMD_DATA_WR: begin
          case (access_r)
            itc_pkg::ACC_LO: begin
              reload_nxt = {8'h00, s1_data_r};
              arm        = 1'b1;
            end
            itc_pkg::ACC_HI: begin
              reload_nxt = {s1_data_r, 8'h00};
              arm        = 1'b1;
            end
            default: begin
              if (!wr_high_r) begin
                reload_nxt  = {reload_r[15:8], s1_data_r};
                wr_high_nxt = 1'b1;
              end else begin
                reload_nxt  = {s1_data_r, reload_r[7:0]};
                wr_high_nxt = 1'b0;
                arm         = 1'b1;
              end
            end
          endcase
          if (arm) begin
            armed_nxt = 1'b1;
            case (mode_r)
              itc_pkg::MODE_SQR: begin
                counter_nxt = {reload_nxt[15:1], 1'b0};
                pin_nxt     = 1'b1;
              end
              itc_pkg::MODE_RATE: begin
                counter_nxt = reload_nxt;
                pin_nxt     = 1'b1;
              end
              default: begin
                counter_nxt = reload_nxt;
                pin_nxt     = 1'b0;
              end
            endcase
          end
        end
        itc_pkg::CMD_DATA_RD: begin
          case (access_r)
            itc_pkg::ACC_LO: begin
              rd_nxt          = src[7:0];
              latch_valid_nxt = 1'b0;
            end
            itc_pkg::ACC_HI: begin
              rd_nxt          = src[15:8];
              latch_valid_nxt = 1'b0;
            end
            default: begin
              if (!rd_high_r) begin
                rd_nxt      = src[7:0];
                rd_high_nxt = 1'b1;
              end else begin
                rd_nxt          = src[15:8];
                rd_high_nxt     = 1'b0;
                latch_valid_nxt = 1'b0;
              end
            end
          endcase
        end
        itc_pkg::CMD_TICK: begin
          if (armed_r) begin
            case (mode_r)
              itc_pkg::MODE_RATE: begin
                if (dec1 == '0) begin
                  counter_nxt = reload_r;
                  pin_nxt     = 1'b1;
                end else begin
                  counter_nxt = dec1;
                  pin_nxt     = (dec1 != 16'd1);
                end
              end
              itc_pkg::MODE_SQR: begin
                if (dec2 == '0) begin
                  counter_nxt = {reload_r[15:1], 1'b0};
                  pin_nxt     = !pin_r;
                end else begin
                  counter_nxt = dec2;
                end
              end
              default: begin
                counter_nxt = dec1;
                if (dec1 == '0) begin
                  pin_nxt = 1'b1;
                end
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      reload_r      <= '0;
      counter_r     <= '0;
      latched_r     <= '0;
      latch_valid_r <= 1'b0;
      wr_high_r     <= 1'b0;
      rd_high_r     <= 1'b0;
      mode_r        <= itc_pkg::MODE_CNT;
      access_r      <= itc_pkg::ACC_LOHI;
      pin_r         <= 1'b0;
      armed_r       <= 1'b0;
    end else begin
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      reload_r      <= reload_nxt;
      counter_r     <= counter_nxt;
      latched_r     <= latched_nxt;
      latch_valid_r <= latch_valid_nxt;
      wr_high_r     <= wr_high_nxt;
      rd_high_r     <= rd_high_nxt;
      mode_r        <= mode_nxt;
      access_r      <= access_nxt;
      pin_r         <= pin_nxt;
      armed_r       <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_cmd_r  <= itc_pkg::cmd_t'(in_if.command);
      s1_data_r <= in_if.write_data;
    end
    if (proc) begin
      out_rd_r    <= rd_nxt;
      out_level_r <= pin_nxt;
      out_irq_r   <= !pin_r && pin_nxt;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.read_data = out_rd_r;
  assign out_if.out_level = out_level_r;
  assign out_if.irq_pulse = out_irq_r;

  `ITC_ASSERT_SAME(a_irq_level, out_valid_r && out_irq_r, out_level_r,
                   "irq pulse without high output")
  `ITC_ASSERT_NEXT(a_rd_zero, proc && s1_cmd_r != itc_pkg::CMD_DATA_RD, out_rd_r == '0,
                   "read data nonzero on a non-read transfer")
  `ITC_ASSERT_NEXT(a_idle_tick, proc && s1_cmd_r == itc_pkg::CMD_TICK && !armed_r,
                   $stable(counter_r) && $stable(pin_r), "unarmed tick changed the count")
  `ITC_ASSERT_NEXT(a_mode_disarm,
                   proc && s1_cmd_r == itc_pkg::CMD_CTRL_WR &&
                   s1_data_r[7:6] == itc_pkg::ChanSel0 && cmd_acc != itc_pkg::ACC_LATCH,
                   !armed_r && !latch_valid_r, "mode write left counter armed or latched")
  `ITC_ASSERT_NEXT(a_no_proc_hold, !proc, $stable(counter_r) && $stable(reload_r),
                   "counter state moved without a processed item")

endmodule
